### src/http_request_head_parser_assert.svh
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// Clocked property with synchronous active-low reset disable
`define HRHP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hrhp assertion failed");

// Non-overlapping implication: consequent checked in the cycle after the antecedent
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `HRHP_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

### src/hrhp_pkg.sv
package hrhp_pkg;

    localparam int VERSION_WIDTH = 8;
    localparam int VW = VERSION_WIDTH;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_US    = 8'h1F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [19:0] {
        PH_METHOD_START = 20'h00001,
        PH_METHOD       = 20'h00002,
        PH_URI          = 20'h00004,
        PH_H            = 20'h00008,
        PH_T1           = 20'h00010,
        PH_T2           = 20'h00020,
        PH_P            = 20'h00040,
        PH_SLASH        = 20'h00080,
        PH_MAJ_START    = 20'h00100,
        PH_MAJ          = 20'h00200,
        PH_MIN_START    = 20'h00400,
        PH_MIN          = 20'h00800,
        PH_LF1          = 20'h01000,
        PH_LINE_START   = 20'h02000,
        PH_LWS          = 20'h04000,
        PH_NAME         = 20'h08000,
        PH_SP_VALUE     = 20'h10000,
        PH_VALUE        = 20'h20000,
        PH_LF2          = 20'h40000,
        PH_LF3          = 20'h80000
    } t_phase;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ROLE_NONE      = 3'd0,
        ROLE_METHOD    = 3'd1,
        ROLE_URI       = 3'd2,
        ROLE_NAME_NEW  = 3'd3,
        ROLE_NAME      = 3'd4,
        ROLE_VALUE     = 3'd5
    } t_role;

    typedef struct packed {
        t_phase          phase;
        logic            header_seen;
        logic [VW-1:0]   major;
        logic [VW-1:0]   minor;
    } t_parse_state;

    typedef struct packed {
        t_status status;
        t_role   role;
    } t_step_res;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_US) || (c == CH_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_tok(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [VW-1:0] acc_digit(input logic [VW-1:0] acc,
                                                input logic [7:0]    c);
        logic [VW+3:0] wide;
        wide = ({4'd0, acc} * (VW+4)'(10)) + {{VW{1'b0}}, c[3:0]};
        return (wide > {4'd0, {VW{1'b1}}}) ? {VW{1'b1}} : wide[VW-1:0];
    endfunction

    function automatic logic [7:0] cap8(input logic [VW-1:0] acc);
        logic [VW+7:0] wide;
        wide = {8'd0, acc};
        return (wide > (VW+8)'(255)) ? 8'hFF : wide[7:0];
    endfunction

endpackage

### src/hrhp_if.sv
interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface hrhp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] byte_role;
    logic [7:0] echo_byte;
    logic [7:0] version_major;
    logic [7:0] version_minor;

    modport source (output valid, output status, output byte_role, output echo_byte,
                    output version_major, output version_minor, input ready);
    modport sink   (input valid, input status, input byte_role, input echo_byte,
                    input version_major, input version_minor, output ready);
endinterface

### src/hrhp_step.sv
module hrhp_step (
    input  hrhp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_restart,
    output hrhp_pkg::t_parse_state o_state,
    output hrhp_pkg::t_step_res    o_res
);
    import hrhp_pkg::*;

    t_parse_state w_cur;
    logic         w_ws;

    assign w_ws = (i_byte == CH_SP) || (i_byte == CH_HT);

    always_comb begin
        w_cur = i_state;
        if (i_restart) begin
            w_cur.phase       = PH_METHOD_START;
            w_cur.header_seen = 1'b0;
        end
        o_state      = w_cur;
        o_res.status = ST_PENDING;
        o_res.role   = ROLE_NONE;

        unique case (w_cur.phase)
            PH_METHOD_START: begin
                if (is_tok(i_byte)) begin
                    o_state.phase = PH_METHOD;
                    o_res.role    = ROLE_METHOD;
                end else o_res.status = ST_BAD;
            end
            PH_METHOD: begin
                if (i_byte == CH_SP) o_state.phase = PH_URI;
                else if (is_tok(i_byte)) o_res.role = ROLE_METHOD;
                else o_res.status = ST_BAD;
            end
            PH_URI: begin
                if (i_byte == CH_SP) o_state.phase = PH_H;
                else if (is_ctl(i_byte)) o_res.status = ST_BAD;
                else o_res.role = ROLE_URI;
            end
            PH_H: begin
                if (i_byte == CH_H) o_state.phase = PH_T1;
                else o_res.status = ST_BAD;
            end
            PH_T1: begin
                if (i_byte == CH_T) o_state.phase = PH_T2;
                else o_res.status = ST_BAD;
            end
            PH_T2: begin
                if (i_byte == CH_T) o_state.phase = PH_P;
                else o_res.status = ST_BAD;
            end
            PH_P: begin
                if (i_byte == CH_P) o_state.phase = PH_SLASH;
                else o_res.status = ST_BAD;
            end
            PH_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    o_state.major = '0;
                    o_state.minor = '0;
                    o_state.phase = PH_MAJ_START;
                end else o_res.status = ST_BAD;
            end
            PH_MAJ_START: begin
                if (is_dig(i_byte)) begin
                    o_state.major = acc_digit(w_cur.major, i_byte);
                    o_state.phase = PH_MAJ;
                end else o_res.status = ST_BAD;
            end
            PH_MAJ: begin
                if (i_byte == CH_DOT) o_state.phase = PH_MIN_START;
                else if (is_dig(i_byte)) o_state.major = acc_digit(w_cur.major, i_byte);
                else o_res.status = ST_BAD;
            end
            PH_MIN_START: begin
                if (is_dig(i_byte)) begin
                    o_state.minor = acc_digit(w_cur.minor, i_byte);
                    o_state.phase = PH_MIN;
                end else o_res.status = ST_BAD;
            end
            PH_MIN: begin
                if (i_byte == CH_CR) o_state.phase = PH_LF1;
                else if (is_dig(i_byte)) o_state.minor = acc_digit(w_cur.minor, i_byte);
                else o_res.status = ST_BAD;
            end
            PH_LF1: begin
                if (i_byte == CH_LF) o_state.phase = PH_LINE_START;
                else o_res.status = ST_BAD;
            end
            PH_LINE_START: begin
                if (i_byte == CH_CR) o_state.phase = PH_LF3;
                else if (w_cur.header_seen && w_ws) o_state.phase = PH_LWS;
                else if (is_tok(i_byte)) begin
                    o_state.header_seen = 1'b1;
                    o_state.phase       = PH_NAME;
                    o_res.role          = ROLE_NAME_NEW;
                end else o_res.status = ST_BAD;
            end
            PH_LWS: begin
                if (i_byte == CH_CR) o_state.phase = PH_LF2;
                else if (w_ws) o_state.phase = PH_LWS;
                else if (is_ctl(i_byte)) o_res.status = ST_BAD;
                else begin
                    o_res.role    = ROLE_VALUE;
                    o_state.phase = PH_VALUE;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_COLON) o_state.phase = PH_SP_VALUE;
                else if (is_tok(i_byte)) o_res.role = ROLE_NAME;
                else o_res.status = ST_BAD;
            end
            PH_SP_VALUE: begin
                if (i_byte == CH_SP) o_state.phase = PH_VALUE;
                else o_res.status = ST_BAD;
            end
            PH_VALUE: begin
                if (i_byte == CH_CR) o_state.phase = PH_LF2;
                else if (is_ctl(i_byte)) o_res.status = ST_BAD;
                else o_res.role = ROLE_VALUE;
            end
            PH_LF2: begin
                if (i_byte == CH_LF) o_state.phase = PH_LINE_START;
                else o_res.status = ST_BAD;
            end
            PH_LF3: begin
                o_res.status = (i_byte == CH_LF) ? ST_DONE : ST_BAD;
            end
            default: begin
                o_res.status = ST_BAD;
            end
        endcase

        // drop every state change on a malformed byte
        if (o_res.status == ST_BAD) o_state = w_cur;
    end

endmodule

### src/http_request_head_parser.sv
// Each accepted byte goes through the input register, then one parse step into the result register;
//   while the result register is stalled, the byte waits in the input register.
// Throughput: one byte per cycle while results are taken; a stalled result holds off input.
// Reset (i_rst_n low, synchronous): both stages empty, phase at method start,
//   header flag and version accumulators cleared.
module http_request_head_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrhp_in_if.sink    i_in,
    hrhp_out_if.source o_out
);
    import hrhp_pkg::*;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_restart;

    t_parse_state  r_state;
    t_parse_state  n_state;
    t_step_res     w_res;

    logic          r_out_valid;
    t_status       r_out_status;
    t_role         r_out_role;
    logic [7:0]    r_out_byte;
    logic [7:0]    r_out_major;
    logic [7:0]    r_out_minor;

    logic          w_adv;
    logic          w_fire;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    hrhp_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_state   (n_state),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte    <= i_in.data_byte;
            r_in_restart <= i_in.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_METHOD_START;
            r_state.header_seen <= 1'b0;
            r_state.major       <= '0;
            r_state.minor       <= '0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_status <= w_res.status;
            r_out_role   <= w_res.role;
            r_out_byte   <= r_in_byte;
            r_out_major  <= cap8(n_state.major);
            r_out_minor  <= cap8(n_state.minor);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.byte_role     = r_out_role;
    assign o_out.echo_byte     = r_out_byte;
    assign o_out.version_major = r_out_major;
    assign o_out.version_minor = r_out_minor;

endmodule

### src/hrhp_checker.sv
`include "http_request_head_parser_assert.svh"

module hrhp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [2:0] i_role,
    input logic [7:0] i_echo
);
    import hrhp_pkg::*;

    `HRHP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                      i_out_valid && $stable({i_status, i_role, i_echo}))
    `HRHP_ASSERT(a_role_only_pending, i_clk, i_rst_n,
                 (i_out_valid && (i_role != ROLE_NONE)) |-> (i_status == ST_PENDING))
    `HRHP_ASSERT(a_done_on_lf, i_clk, i_rst_n,
                 (i_out_valid && (i_status == ST_DONE)) |-> (i_echo == CH_LF))
    `HRHP_ASSERT(a_beat_lands, i_clk, i_rst_n, (i_in_valid && i_in_ready) |-> ##2 i_out_valid)

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_role      (o_out.byte_role),
    .i_echo      (o_out.echo_byte)
);

### test/hrhp_head_checker.sv
module hrhp_head_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hrhp_in_if   i_in,
    hrhp_out_if  i_out,
    output int   o_mismatches,
    output int   o_backlog
);
    import hrhp_pkg::*;

    typedef struct packed {
        t_status    status;
        t_role      role;
        logic [7:0] echo;
        logic [7:0] major;
        logic [7:0] minor;
    } t_head_beat;

    t_head_beat    expected_beats [$];
    t_phase        phase_q;
    logic          hdr_seen_q;
    logic [VW-1:0] major_q;
    logic [VW-1:0] minor_q;

    function automatic logic is_control(input logic [7:0] c);
        return (c <= CH_US) || (c == CH_DEL);
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        if (c[7] || is_control(c)) return 1'b0;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
            "[", "]", "?", "=", "{", "}", CH_SP, CH_HT: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [VW-1:0] bump_version(input logic [VW-1:0] acc,
                                                   input logic [7:0]    c);
        int v;
        v = int'(acc) * 10 + int'(c - CH_ZERO);
        return (v > (1 << VW) - 1) ? {VW{1'b1}} : VW'(v);
    endfunction

    function automatic logic [7:0] cap_byte(input logic [VW-1:0] acc);
        return (int'(acc) > 255) ? 8'hFF : 8'(acc);
    endfunction

    function automatic t_head_beat advance_parser(input logic [7:0] c, input logic rs);
        t_head_beat r;
        t_phase     nxt;
        r.status = ST_PENDING;
        r.role   = ROLE_NONE;
        r.echo   = c;
        if (rs) begin
            phase_q    = PH_METHOD_START;
            hdr_seen_q = 1'b0;
        end
        nxt = phase_q;
        case (phase_q)
            PH_METHOD_START: begin
                if (is_token(c)) begin
                    nxt    = PH_METHOD;
                    r.role = ROLE_METHOD;
                end else r.status = ST_BAD;
            end
            PH_METHOD: begin
                if (c == CH_SP) nxt = PH_URI;
                else if (is_token(c)) r.role = ROLE_METHOD;
                else r.status = ST_BAD;
            end
            PH_URI: begin
                if (c == CH_SP) nxt = PH_H;
                else if (is_control(c)) r.status = ST_BAD;
                else r.role = ROLE_URI;
            end
            PH_H:  if (c == CH_H) nxt = PH_T1; else r.status = ST_BAD;
            PH_T1: if (c == CH_T) nxt = PH_T2; else r.status = ST_BAD;
            PH_T2: if (c == CH_T) nxt = PH_P; else r.status = ST_BAD;
            PH_P:  if (c == CH_P) nxt = PH_SLASH; else r.status = ST_BAD;
            PH_SLASH: begin
                if (c == CH_SLASH) begin
                    major_q = '0;
                    minor_q = '0;
                    nxt     = PH_MAJ_START;
                end else r.status = ST_BAD;
            end
            PH_MAJ_START: begin
                if (is_digit(c)) begin
                    major_q = bump_version(major_q, c);
                    nxt     = PH_MAJ;
                end else r.status = ST_BAD;
            end
            PH_MAJ: begin
                if (c == CH_DOT) nxt = PH_MIN_START;
                else if (is_digit(c)) major_q = bump_version(major_q, c);
                else r.status = ST_BAD;
            end
            PH_MIN_START: begin
                if (is_digit(c)) begin
                    minor_q = bump_version(minor_q, c);
                    nxt     = PH_MIN;
                end else r.status = ST_BAD;
            end
            PH_MIN: begin
                if (c == CH_CR) nxt = PH_LF1;
                else if (is_digit(c)) minor_q = bump_version(minor_q, c);
                else r.status = ST_BAD;
            end
            PH_LF1: if (c == CH_LF) nxt = PH_LINE_START; else r.status = ST_BAD;
            PH_LINE_START: begin
                if (c == CH_CR) nxt = PH_LF3;
                else if (hdr_seen_q && (c == CH_SP || c == CH_HT)) nxt = PH_LWS;
                else if (is_token(c)) begin
                    hdr_seen_q = 1'b1;
                    r.role     = ROLE_NAME_NEW;
                    nxt        = PH_NAME;
                end else r.status = ST_BAD;
            end
            PH_LWS: begin
                if (c == CH_CR) nxt = PH_LF2;
                else if (c == CH_SP || c == CH_HT) nxt = PH_LWS;
                else if (is_control(c)) r.status = ST_BAD;
                else begin
                    r.role = ROLE_VALUE;
                    nxt    = PH_VALUE;
                end
            end
            PH_NAME: begin
                if (c == CH_COLON) nxt = PH_SP_VALUE;
                else if (is_token(c)) r.role = ROLE_NAME;
                else r.status = ST_BAD;
            end
            PH_SP_VALUE: if (c == CH_SP) nxt = PH_VALUE; else r.status = ST_BAD;
            PH_VALUE: begin
                if (c == CH_CR) nxt = PH_LF2;
                else if (is_control(c)) r.status = ST_BAD;
                else r.role = ROLE_VALUE;
            end
            PH_LF2: if (c == CH_LF) nxt = PH_LINE_START; else r.status = ST_BAD;
            PH_LF3: r.status = (c == CH_LF) ? ST_DONE : ST_BAD;
            default: r.status = ST_BAD;
        endcase
        phase_q = nxt;
        r.major = cap_byte(major_q);
        r.minor = cap_byte(minor_q);
        return r;
    endfunction

    function automatic int field_differs(input string name, input int want, input int got);
        if (want == got) return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        int         errs;
        t_head_beat want;
        errs = 0;
        if (!i_rst_n) begin
            phase_q    = PH_METHOD_START;
            hdr_seen_q = 1'b0;
            major_q    = '0;
            minor_q    = '0;
            expected_beats.delete();
            o_mismatches <= 0;
            o_backlog    <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                expected_beats = {expected_beats,
                                  advance_parser(i_in.data_byte, i_in.restart)};
            if (i_out.valid && i_out.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with no prediction pending, echo_byte %0d",
                           i_out.echo_byte);
                    errs++;
                end else begin
                    want = expected_beats.pop_front();
                    errs += field_differs("status", want.status, i_out.status);
                    errs += field_differs("byte_role", want.role, i_out.byte_role);
                    errs += field_differs("echo_byte", want.echo, i_out.echo_byte);
                    errs += field_differs("version_major", want.major, i_out.version_major);
                    errs += field_differs("version_minor", want.minor, i_out.version_minor);
                end
            end
            o_mismatches <= o_mismatches + errs;
            o_backlog    <= expected_beats.size();
        end
    end

endmodule

### test/tb_top.sv
module tb_top;
    import hrhp_pkg::*;

    localparam int TOTAL_ITEMS = 1950;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   backlog;
    int   hold_ask = 0;
    int   items_sent = 0;
    int   gap_pct = 30;
    int   noise_pct = 0;
    int   head_left = 0;

    string token_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_|~";

    logic [7:0] opening_bytes [$] = '{
        "G", "E", CH_SP, 8'hFF, 8'h00, CH_SP, CH_H, CH_T, CH_T, CH_P, CH_SLASH,
        "9", "9", "9", CH_DOT, "1", CH_CR, CH_LF, CH_SP, CH_CR, CH_LF, CH_LF, "x"
    };

    hrhp_in_if  in_ch ();
    hrhp_out_if out_ch ();

    http_request_head_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    hrhp_head_checker head_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_backlog    (backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] token_byte();
        return token_chars[$urandom_range(0, token_chars.len() - 1)];
    endfunction

    function automatic logic [7:0] text_byte(input logic allow_space);
        logic [7:0] b;
        do b = 8'($urandom_range(CH_SP, 255));
        while (b == CH_DEL || (!allow_space && b == CH_SP));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? CH_SP : CH_HT;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.restart   <= rs;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic emit(input logic [7:0] b, input logic rs);
        if (head_left == 0) return;
        head_left--;
        if ($urandom_range(0, 99) < noise_pct)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
        send_byte(b, rs);
    endtask

    task automatic emit_number();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 4) : 1;
        repeat (n) emit(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic emit_line_end();
        emit(CH_CR, 1'b0);
        emit(CH_LF, 1'b0);
    endtask

    task automatic send_head();
        int n_hdr;
        head_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 1 << 20;
        noise_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 20) : 0;
        emit(token_byte(), $urandom_range(0, 19) != 0);
        repeat ($urandom_range(0, 6)) emit(token_byte(), 1'b0);
        emit(CH_SP, 1'b0);
        repeat ($urandom_range(1, 12)) emit(text_byte(1'b0), 1'b0);
        emit(CH_SP, 1'b0);
        emit(CH_H, 1'b0);
        emit(CH_T, 1'b0);
        emit(CH_T, 1'b0);
        emit(CH_P, 1'b0);
        emit(CH_SLASH, 1'b0);
        emit_number();
        emit(CH_DOT, 1'b0);
        emit_number();
        emit_line_end();
        n_hdr = $urandom_range(0, 4);
        if (n_hdr == 0 && $urandom_range(0, 2) == 0) emit(blank_byte(), 1'b0);
        repeat (n_hdr) begin
            emit(token_byte(), 1'b0);
            repeat ($urandom_range(0, 7)) emit(token_byte(), 1'b0);
            emit(CH_COLON, 1'b0);
            emit(CH_SP, 1'b0);
            repeat ($urandom_range(0, 10)) emit(text_byte(1'b1), 1'b0);
            emit_line_end();
            if ($urandom_range(0, 3) == 0) begin
                emit(blank_byte(), 1'b0);
                repeat ($urandom_range(0, 2)) emit(blank_byte(), 1'b0);
                repeat ($urandom_range(0, 6)) emit(text_byte(1'b1), 1'b0);
                emit_line_end();
            end
        end
        emit_line_end();
        case ($urandom_range(0, 5))
            0: emit(CH_LF, 1'b0);
            1: emit(token_byte(), 1'b0);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (backlog != 0);
    endtask

    initial begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.restart   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening_bytes[i]) send_byte(opening_bytes[i], i == 0);
        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = $urandom_range(5, 20);
                default: gap_pct = $urandom_range(30, 70);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 20))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                send_head();
            end
            if (!held && items_sent > 600) begin
                hold_ask <= hold_ask + 1;
                held = 1'b1;
            end
            if ((!paused && items_sent > 1200) || $urandom_range(0, 14) == 0) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && backlog == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int holds_done;
        int mode_left;
        int stall_pct;
        int n;
        holds_done = 0;
        mode_left  = 0;
        stall_pct  = 0;
        forever begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 300);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            end
            if (hold_ask != holds_done) begin
                holds_done++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < stall_pct) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
            mode_left--;
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/hrhp_pkg.sv
src/hrhp_if.sv
src/hrhp_step.sv
src/http_request_head_parser.sv
src/hrhp_checker.sv
test/hrhp_head_checker.sv
test/tb_top.sv
